// ----- rtl/scs_pkg.sv -----
// scs_pkg: payload structs, request codes and queue entry layout for the
// self-modifying key stream cipher; no dependencies
`default_nettype none

package scs_pkg;

   // request codes
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_CRYPT = 1'b1;

   // length arithmetic wide enough for the largest supported key (256)
   localparam int LEN_W  = 9;
   localparam int ADDR_W = 8;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic       req_type;
      logic [6:0] key_index;
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       buffer_end_out;
   } rsp_item_type;

   typedef struct packed {
      logic              is_crypt;
      logic [ADDR_W-1:0] addr;
      logic              wrap;
      logic              store_ok;
      logic [7:0]        data;
      logic              buffer_end;
   } queue_entry_type;

endpackage

`default_nettype wire

// ----- rtl/scs_front.sv -----
// scs_front: accepts requests, holds the key length register and the key
// position, and turns each request into a queue entry; uses scs_pkg
`default_nettype none

module scs_front import scs_pkg::*; #(
   parameter int MaxKeyLength = 128
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_item_type    req_payload,
   input  logic            csr_wr_en,
   input  logic [7:0]      csr_wr_data,
   output logic            push,
   output queue_entry_type push_entry,
   input  logic            queue_full
);

   localparam int PosW = (MaxKeyLength > 1) ? $clog2(MaxKeyLength) : 1;
   localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MaxKeyLength);

   logic [7:0]       len_ff, len_in;
   logic [PosW-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0] used_len, pos_plus;
   logic             at_end;
   logic             accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   always_comb begin
      if (len_ff == 8'd0) begin
         used_len = LEN_W'(1);
      end else if ({1'b0, len_ff} > MaxLen) begin
         used_len = MaxLen;
      end else begin
         used_len = {1'b0, len_ff};
      end
      pos_plus = LEN_W'(pos_ff) + LEN_W'(1);
      at_end   = (pos_plus >= used_len);
   end

   always_comb begin
      push_entry.is_crypt   = (req_payload.req_type == REQ_CRYPT);
      push_entry.wrap       = at_end;
      push_entry.store_ok   = ({2'b00, req_payload.key_index} < MaxLen);
      push_entry.data       = req_payload.data_byte;
      push_entry.buffer_end = req_payload.buffer_end;
      if (req_payload.req_type == REQ_CRYPT) begin
         push_entry.addr = ADDR_W'(pos_ff);
      end else begin
         push_entry.addr = {1'b0, req_payload.key_index};
      end
   end

   always_comb begin
      len_in = csr_wr_en ? csr_wr_data : len_ff;
      pos_in = pos_ff;
      if (accept) begin
         if (req_payload.req_type == REQ_LOAD || at_end) begin
            pos_in = '0;
         end else begin
            pos_in = pos_plus[PosW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= 8'd1;
         pos_ff <= '0;
      end else begin
         len_ff <= len_in;
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/scs_queue.sv -----
// scs_queue: small first-in first-out queue of decoded entries between the
// front and back ends; uses scs_pkg
`default_nettype none

module scs_queue import scs_pkg::*; #(
   parameter int Depth = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   input  logic            pop,
   output queue_entry_type head,
   output logic            full,
   output logic            empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   queue_entry_type slots_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ptr_ff];

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
      next_ptr = (ptr == PtrW'(Depth - 1)) ? '0 : ptr + PtrW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/scs_back.sv -----
// scs_back: key memory, key update and output register; takes decoded
// entries from the queue; uses scs_pkg
`default_nettype none

module scs_back import scs_pkg::*; #(
   parameter int MaxKeyLength = 128
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            queue_empty,
   output logic            pop,
   input  queue_entry_type head,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_item_type    rsp_payload
);

   localparam int PosW = (MaxKeyLength > 1) ? $clog2(MaxKeyLength) : 1;

   typedef enum logic {ST_FETCH, ST_EXEC} state_type;

   logic [7:0]      key_mem [MaxKeyLength];
   state_type       state_ff, state_in;
   queue_entry_type cur_ff, cur_in;
   logic [7:0]      k0_ff, k0_in, mul_ff, mul_in;
   logic [7:0]      rd_pos_ff, rd_next_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_item_type    rsp_ff, rsp_in;
   logic            mem_we;
   logic [PosW-1:0] mem_waddr, rd_addr_a, rd_addr_b;
   logic [7:0]      mem_wdata, addend, sum_raw, sum_fix;
   logic [15:0]     product;
   logic            rd_en, out_free, exec_fire;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      pop       = (state_ff == ST_FETCH) && !queue_empty;
      rd_en     = pop && head.is_crypt;
      exec_fire = (state_ff == ST_EXEC) && out_free;
      rd_addr_a = head.addr[PosW-1:0];
      rd_addr_b = rd_addr_a + PosW'(1);
      product   = 16'(k0_ff) * 16'(head.addr);
      mul_in    = rd_en ? product[7:0] : mul_ff;
      cur_in    = rd_en ? head : cur_ff;

      addend  = cur_ff.wrap ? k0_ff : rd_next_ff;
      sum_raw = rd_pos_ff + addend;
      sum_fix = (sum_raw == 8'd0) ? 8'd1 : sum_raw;

      mem_we    = 1'b0;
      mem_waddr = cur_ff.addr[PosW-1:0];
      mem_wdata = sum_fix;
      if (exec_fire) begin
         mem_we = 1'b1;
      end else if (pop && !head.is_crypt && head.store_ok) begin
         mem_we    = 1'b1;
         mem_waddr = head.addr[PosW-1:0];
         mem_wdata = head.data;
      end
      k0_in = (mem_we && mem_waddr == '0) ? mem_wdata : k0_ff;

      state_in = state_ff;
      unique case (state_ff)
         ST_FETCH: begin
            if (rd_en) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = ST_FETCH;
            end
         end
         default: state_in = ST_FETCH;
      endcase

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (exec_fire) begin
         rsp_valid_in          = 1'b1;
         rsp_in.out_byte       = cur_ff.data ^ rd_pos_ff ^ mul_ff;
         rsp_in.buffer_end_out = cur_ff.buffer_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FETCH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      mul_ff <= mul_in;
      k0_ff  <= k0_in;
      rsp_ff <= rsp_in;
   end

   // key memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_pos_ff  <= key_mem[rd_addr_a];
         rd_next_ff <= key_mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/self_modifying_key_stream_cipher.sv -----
// Byte stream cipher with a self-modifying key. A load request writes one key
// byte and returns the key position to zero; it gives no response. A crypt
// request gives one response: a fetch state reads key[pos] and key[pos+1]
// from the key memory, then an execute state forms the output byte and writes
// the updated key byte back. No new request leaves the queue until that crypt
// is done, and a crypt passes through a queue slot, the key read registers
// and the response register. A four-entry queue separates request acceptance
// from the key memory, and a response register lets the next byte be worked
// on while a result waits. The key memory is not cleared after reset: load
// every key byte in use before the first crypt. Write the key length only
// while the block is idle.
// Depends on scs_pkg, scs_front, scs_queue and scs_back.
`default_nettype none

module self_modifying_key_stream_cipher import scs_pkg::*; #(
   parameter int MaxKeyLength = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_payload,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data
);

   logic            push, pop, queue_full, queue_empty;
   queue_entry_type push_entry, head;

   scs_front #(.MaxKeyLength(MaxKeyLength)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   scs_queue #(.Depth(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (head),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   scs_back #(.MaxKeyLength(MaxKeyLength)) u_back (
      .clock      (clock),
      .reset      (reset),
      .queue_empty(queue_empty),
      .pop        (pop),
      .head       (head),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire

// ----- rtl/scs_checker.sv -----
// scs_checker: port-level assertions for the cipher top level, attached by
// bind; uses scs_pkg
`default_nettype none

module scs_checker import scs_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_item_type req_payload,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_payload
);

   // no response can be ready straight after reset
   a_no_early_rsp : assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("response appeared too soon after reset");

   // queue is empty after reset so requests are taken at once
   a_ready_after_reset : assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("request stalled straight after reset");

   // a stalled response holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // a load never produces a response on its own from an idle block
   a_load_silent : assert property (@(posedge clock) disable iff (reset)
      $past(reset) && req_valid && !req_stall && req_payload.req_type == REQ_LOAD
      |=> ##2 !rsp_valid)
      else $error("load request produced a response");

endmodule

bind self_modifying_key_stream_cipher scs_checker u_scs_checker (.*);

`default_nettype wire

// ----- tb/self_modifying_key_stream_cipher_tb.sv -----
// testbench for the self-modifying key stream cipher: directed key, length and
// back-pressure tests plus random traffic, each response checked against a
// cycle-free prediction of the key stream; depends on scs_pkg and the rtl top
module self_modifying_key_stream_cipher_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import scs_pkg::*;

   localparam int KEY_DEPTH     = 128;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 80;
   localparam int CYCLE_LIMIT   = 400000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_payload;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_payload;
   logic         csr_wr_en;
   logic [7:0]   csr_wr_data;

   logic [7:0]   key_model [KEY_DEPTH];
   bit           key_written [KEY_DEPTH];
   int unsigned  key_pos = 0;
   logic [7:0]   key_length_reg = 8'd1;
   rsp_item_type expected_bytes [$];
   rsp_item_type oldest_byte;
   int           failures = 0;
   int           cycle_count = 0;
   bit           req_idle_on = 1'b1;
   bit           rsp_idle_on = 1'b1;
   bit           hold_request = 1'b0;
   int           stall_left = 0;
   int           hold_left = 0;

   self_modifying_key_stream_cipher DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver side: random stall bursts and one long hold on demand
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_payload);
            failures++;
         end else begin
            oldest_byte = expected_bytes.pop_front();
            if (rsp_payload.out_byte !== oldest_byte.out_byte) begin
               $display("%0t: out_byte mismatch, expected %02h, actual %02h", $time,
                        oldest_byte.out_byte, rsp_payload.out_byte);
               failures++;
            end
            if (rsp_payload.buffer_end_out !== oldest_byte.buffer_end_out) begin
               $display("%0t: buffer_end_out mismatch, expected %b, actual %b", $time,
                        oldest_byte.buffer_end_out, rsp_payload.buffer_end_out);
               failures++;
            end
         end
      end
   end

   function automatic int unsigned effective_length();
      if (key_length_reg == 8'd0)
         return 1;
      if (key_length_reg > KEY_DEPTH)
         return KEY_DEPTH;
      return 32'(key_length_reg);
   endfunction

   function automatic rsp_item_type crypt_step(input logic [7:0] data, input logic last);
      int unsigned  len;
      int unsigned  p;
      logic [7:0]   k0;
      logic [7:0]   addend;
      logic [7:0]   sum;
      rsp_item_type result;
      len = effective_length();
      p = key_pos;
      k0 = key_model[0];
      result.out_byte = data ^ key_model[p] ^ 8'(k0 * p);
      result.buffer_end_out = last;
      addend = (p + 1 < len) ? key_model[p + 1] : k0;
      sum = key_model[p] + addend;
      if (sum == 8'd0)
         sum = 8'd1;
      key_model[p] = sum;
      p++;
      if (p >= len)
         p = 0;
      key_pos = p;
      return result;
   endfunction

   task automatic send_request(input logic kind, input logic [6:0] idx,
                               input logic [7:0] data, input logic last);
      req_item_type item;
      item.req_type = kind;
      item.key_index = idx;
      item.data_byte = data;
      item.buffer_end = last;
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      if (kind == REQ_LOAD) begin
         key_model[idx] = data;
         key_written[idx] = 1'b1;
         key_pos = 0;
      end else begin
         expected_bytes.push_back(crypt_step(data, last));
      end
   endtask

   task automatic send_random_crypt();
      send_request(REQ_CRYPT, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 3) == 0));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key_length(input logic [7:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      key_length_reg = value;
   endtask

   // every key byte in use, plus the one after it, must hold a written value
   task automatic ensure_key_loaded();
      int unsigned top;
      top = effective_length();
      if (top > KEY_DEPTH - 1)
         top = KEY_DEPTH - 1;
      for (int i = 0; i <= top; i++)
         if (!key_written[i])
            send_request(REQ_LOAD, 7'(i), 8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic test_key_extremes();
      write_key_length(8'd0);
      send_request(REQ_LOAD, 7'd0, 8'h00, 1'b0);
      send_request(REQ_LOAD, 7'd1, 8'hFF, 1'b1);
      send_request(REQ_LOAD, 7'd127, 8'hFF, 1'b0);
      // zero key byte added to itself gives zero and is forced to one
      send_request(REQ_CRYPT, 7'd0, 8'h00, 1'b0);
      send_request(REQ_CRYPT, 7'd127, 8'hFF, 1'b1);
      write_key_length(8'd2);
      send_request(REQ_LOAD, 7'd0, 8'h80, 1'b0);
      send_request(REQ_LOAD, 7'd1, 8'h80, 1'b0);
      send_request(REQ_LOAD, 7'd2, 8'h01, 1'b0);
      send_request(REQ_CRYPT, 7'd0, 8'hA5, 1'b0);
      send_request(REQ_CRYPT, 7'd0, 8'h5A, 1'b1);
      send_request(REQ_CRYPT, 7'd127, 8'hFF, 1'b0);
      send_request(REQ_CRYPT, 7'd0, 8'h00, 1'b1);
   endtask

   task automatic test_length_lowered();
      write_key_length(8'd4);
      ensure_key_loaded();
      send_request(REQ_LOAD, 7'd0, 8'h37, 1'b0);
      repeat (3) send_random_crypt();
      // position now past the end of the shorter key
      write_key_length(8'd2);
      repeat (4) send_random_crypt();
   endtask

   task automatic test_random_traffic();
      logic [7:0] len;
      for (int phase = 0; phase < 13; phase++) begin
         if (phase == 0)
            len = 8'd128;
         else if (phase == 1)
            len = 8'd255;
         else begin
            case ($urandom_range(0, 4))
               0: len = 8'($urandom_range(129, 255));
               1: len = 8'($urandom_range(0, 1));
               2: len = 8'($urandom_range(17, 128));
               default: len = 8'($urandom_range(2, 16));
            endcase
         end
         req_idle_on = (phase % 3 != 2);
         rsp_idle_on = (phase % 4 != 3);
         write_key_length(len);
         ensure_key_loaded();
         repeat (100) begin
            if ($urandom_range(0, 11) == 0)
               send_request(REQ_LOAD, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
            else
               send_random_crypt();
         end
      end
   endtask

   task automatic test_backpressure();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      ensure_key_loaded();
      hold_request = 1'b1;
      repeat (40) send_random_crypt();
   endtask

   task automatic test_quiet_tail();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      write_key_length(8'($urandom_range(1, 32)));
      ensure_key_loaded();
      repeat (150) send_random_crypt();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 8'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_key_extremes();
      test_length_lowered();
      test_random_traffic();
      test_backpressure();
      test_quiet_tail();
      wait_idle();
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- self_modifying_key_stream_cipher.f -----
rtl/scs_pkg.sv
rtl/scs_front.sv
rtl/scs_queue.sv
rtl/scs_back.sv
rtl/self_modifying_key_stream_cipher.sv
rtl/scs_checker.sv
tb/self_modifying_key_stream_cipher_tb.sv
